>>> rtl/core/spam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spam_pkg: shared types and constants
// Word layouts, operation codes and saturation limits of the sparse
// polynomial adder and multiplier.
// ----------------------------------------------------------------------------
package spam_pkg;

  localparam int MaxTerms  = 8;
  localparam int CoeffBits = 16;
  localparam int ExpBits   = 8;
  localparam int AccBits   = 35;
  localparam int RexpBits  = 9;
  localparam int BankDepth = 64;
  localparam int BankAw    = 6;

  localparam logic [1:0] OpLoadA   = 2'd0;
  localparam logic [1:0] OpLoadB   = 2'd1;
  localparam logic [1:0] OpSum     = 2'd2;
  localparam logic [1:0] OpProduct = 2'd3;

  localparam logic signed [AccBits-1:0] SatHi = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic signed [AccBits-1:0] SatLo = {1'b1, {(AccBits-1){1'b0}}};

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] term_coefficient;
    logic [7:0]         term_exponent;
  } in_word_t;

  typedef struct packed {
    logic signed [AccBits-1:0] result_coefficient;
    logic [RexpBits-1:0]       result_exponent;
    logic                      term_valid;
    logic                      last_term;
    logic                      terms_dropped;
  } out_word_t;

  // Saturating 35-bit add
  function automatic logic signed [AccBits-1:0] sat_add(
      input logic signed [AccBits-1:0] a, input logic signed [AccBits-1:0] b);
    logic signed [AccBits:0] s;
    s = {a[AccBits-1], a} + {b[AccBits-1], b};
    if (s[AccBits] != s[AccBits-1]) begin
      sat_add = s[AccBits] ? SatLo : SatHi;
    end else begin
      sat_add = s[AccBits-1:0];
    end
  endfunction

endpackage

>>> rtl/core/spam_accum_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spam_accum_mem: accumulator bank memory
// Two banks of merged terms in one synchronous RAM, one write and one read
// port, read data registered.
// ----------------------------------------------------------------------------
module spam_accum_mem #(
  parameter int Aw = spam_pkg::BankAw + 1,
  parameter int Dw = spam_pkg::AccBits + spam_pkg::RexpBits
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [Dw-1:0] wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [Dw-1:0] rdata_o
);

  logic [Dw-1:0] mem_q [2**Aw];

  // Write and registered read; a read of the word being written returns its old value
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/sparse_polynomial_add_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_add_multiply: sparse polynomial adder and multiplier
// Loads two term lists and emits their sum or product as a run of terms.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_i with start_i high while busy_o is low; the word
//   is taken at that edge. Operation 0 and 1 load a term of A or B (no
//   result; a load into a full store is dropped and flagged). Operation 2
//   emits A+B and operation 3 emits A*B as a run of words on out_o, each
//   marked by valid_o for exactly one cycle; the run ends with last_term set.
//   An empty result gives one marker word with term_valid low.
// Timing:
//   A compute merges term lists through the accumulator RAM: each merge
//   step runs StRead then StMerge (registered read, then write), and each
//   emitted word runs StEmitRd then StEmit. The RAM has a single read port.
//   busy_o is high for the whole compute.
// Reset:
//   rst_ni clears counts, the drop flag and the controller; term stores and
//   the RAM hold no reset value. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_multiply #(
  parameter int MaxTerms  = spam_pkg::MaxTerms,
  parameter int CoeffBits = spam_pkg::CoeffBits,
  parameter int ExpBits   = spam_pkg::ExpBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  spam_pkg::in_word_t  in_i,
  output logic                busy_o,
  output logic                valid_o,
  output spam_pkg::out_word_t out_o
);

  localparam int Aw  = spam_pkg::AccBits;
  localparam int Rw  = spam_pkg::RexpBits;
  localparam int Bw  = spam_pkg::BankAw;
  localparam int Tw  = $clog2(MaxTerms + 1);
  localparam int Iw  = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;

  typedef enum logic [2:0] {
    StIdle, StRead, StMerge, StEmitRd, StEmit
  } state_e;

  // Term stores
  logic signed [CoeffBits-1:0] a_coef_q [MaxTerms];
  logic [ExpBits-1:0]          a_exp_q  [MaxTerms];
  logic signed [CoeffBits-1:0] b_coef_q [MaxTerms];
  logic [ExpBits-1:0]          b_exp_q  [MaxTerms];
  logic [Tw-1:0]               a_cnt_q, b_cnt_q;
  logic                        drop_q;

  state_e        state_q;
  logic          prod_q;
  logic          src_q;
  logic [Bw:0]   src_cnt_q, dst_cnt_q;
  logic [Bw:0]   i_q;
  logic [Tw-1:0] j_q;
  logic [Tw-1:0] k_q;

  logic          accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StIdle);

  // RAM ports
  logic            we;
  logic [Bw:0]     waddr, raddr;
  logic [Aw+Rw-1:0] wdata, rdata;

  spam_accum_mem #(.Aw(Bw + 1), .Dw(Aw + Rw)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Left operand: accumulator bank (product) or A (sum)
  logic signed [Aw-1:0] l_coef, r_coef, sum;
  logic [Rw-1:0]        l_exp, r_exp;
  logic                 l_has, r_has;
  logic [Iw-1:0]        ii, jj, kk;
  logic signed [2*CoeffBits-1:0] prod;

  assign ii = i_q[Iw-1:0];
  assign jj = j_q[Iw-1:0];
  assign kk = k_q[Iw-1:0];
  assign prod = a_coef_q[kk] * b_coef_q[jj];

  always_comb begin
    if (prod_q) begin
      l_has  = (i_q < src_cnt_q);
      l_coef = rdata[Aw+Rw-1:Rw];
      l_exp  = rdata[Rw-1:0];
      r_has  = (j_q < b_cnt_q);
      r_coef = Aw'(prod);
      r_exp  = Rw'(a_exp_q[kk]) + Rw'(b_exp_q[jj]);
    end else begin
      l_has  = (i_q < (Bw+1)'(a_cnt_q));
      l_coef = Aw'(a_coef_q[ii]);
      l_exp  = Rw'(a_exp_q[ii]);
      r_has  = (j_q < b_cnt_q);
      r_coef = Aw'(b_coef_q[jj]);
      r_exp  = Rw'(b_exp_q[jj]);
    end
    sum = spam_pkg::sat_add(l_coef, r_coef);
  end

  // Merge decision
  logic take_l, take_r, put_en;
  logic signed [Aw-1:0] put_coef;
  logic [Rw-1:0]        put_exp;
  always_comb begin
    take_l = 1'b0;
    take_r = 1'b0;
    put_coef = l_coef;
    put_exp  = l_exp;
    put_en   = 1'b1;
    priority if (l_has && r_has && l_exp == r_exp) begin
      take_l = 1'b1;
      take_r = 1'b1;
      put_coef = sum;
      put_en = (sum != '0);
    end else if (l_has && r_has && l_exp < r_exp) begin
      take_r = 1'b1;
      put_coef = r_coef;
      put_exp = r_exp;
    end else if (l_has) begin
      take_l = 1'b1;
    end else if (r_has) begin
      take_r = 1'b1;
      put_coef = r_coef;
      put_exp = r_exp;
    end else begin
      put_en = 1'b0;
    end
  end

  logic dst;
  assign dst = prod_q ? ~src_q : 1'b0;
  assign we    = (state_q == StMerge) && put_en && (dst_cnt_q < (Bw+1)'(spam_pkg::BankDepth));
  assign waddr = {dst, dst_cnt_q[Bw-1:0]};
  assign wdata = {put_coef, put_exp};
  always_comb begin
    raddr = {src_q, i_q[Bw-1:0]};
    if (state_q == StEmitRd) begin
      raddr = {src_q, i_q[Bw-1:0]};
    end
  end

  // Controller and stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      a_cnt_q   <= '0;
      b_cnt_q   <= '0;
      drop_q    <= 1'b0;
      prod_q    <= 1'b0;
      src_q     <= 1'b0;
      src_cnt_q <= '0;
      dst_cnt_q <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      valid_o   <= 1'b0;
      out_o     <= '0;
    end else begin
      valid_o <= (state_q == StEmit);
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            unique case (in_i.operation)
              spam_pkg::OpLoadA: begin
                if (a_cnt_q < Tw'(MaxTerms)) begin
                  a_coef_q[a_cnt_q[Iw-1:0]] <= in_i.term_coefficient[CoeffBits-1:0];
                  a_exp_q[a_cnt_q[Iw-1:0]]  <= in_i.term_exponent[ExpBits-1:0];
                  a_cnt_q <= a_cnt_q + 1'b1;
                end else begin
                  drop_q <= 1'b1;
                end
              end
              spam_pkg::OpLoadB: begin
                if (b_cnt_q < Tw'(MaxTerms)) begin
                  b_coef_q[b_cnt_q[Iw-1:0]] <= in_i.term_coefficient[CoeffBits-1:0];
                  b_exp_q[b_cnt_q[Iw-1:0]]  <= in_i.term_exponent[ExpBits-1:0];
                  b_cnt_q <= b_cnt_q + 1'b1;
                end else begin
                  drop_q <= 1'b1;
                end
              end
              default: begin
                prod_q    <= (in_i.operation == spam_pkg::OpProduct);
                src_cnt_q <= '0;
                dst_cnt_q <= '0;
                i_q       <= '0;
                j_q       <= '0;
                k_q       <= '0;
                if (in_i.operation == spam_pkg::OpProduct && a_cnt_q == '0) begin
                  src_q   <= 1'b0;
                  state_q <= StEmitRd;
                end else begin
                  src_q   <= 1'b1;
                  state_q <= StRead;
                end
              end
            endcase
          end
        end
        // Wait for the accumulator word
        StRead: state_q <= StMerge;
        StMerge: begin
          if (!l_has && !r_has) begin
            // Row done: flip banks or finish
            src_q     <= dst;
            src_cnt_q <= dst_cnt_q;
            dst_cnt_q <= '0;
            i_q       <= '0;
            j_q       <= '0;
            if (prod_q && (k_q + 1'b1) < a_cnt_q) begin
              k_q     <= k_q + 1'b1;
              state_q <= StRead;
            end else begin
              state_q <= StEmitRd;
            end
          end else begin
            if (put_en && dst_cnt_q < (Bw+1)'(spam_pkg::BankDepth)) begin
              dst_cnt_q <= dst_cnt_q + 1'b1;
            end
            if (take_l) i_q <= i_q + 1'b1;
            if (take_r) j_q <= j_q + 1'b1;
            state_q <= StRead;
          end
        end
        StEmitRd: state_q <= StEmit;
        StEmit: begin
          out_o.terms_dropped <= drop_q;
          if (src_cnt_q == '0) begin
            out_o.result_coefficient <= '0;
            out_o.result_exponent    <= '0;
            out_o.term_valid         <= 1'b0;
            out_o.last_term          <= 1'b1;
          end else begin
            out_o.result_coefficient <= rdata[Aw+Rw-1:Rw];
            out_o.result_exponent    <= rdata[Rw-1:0];
            out_o.term_valid         <= 1'b1;
            out_o.last_term          <= (i_q + 1'b1 == src_cnt_q);
          end
          if (src_cnt_q == '0 || i_q + 1'b1 == src_cnt_q) begin
            state_q <= StIdle;
            a_cnt_q <= '0;
            b_cnt_q <= '0;
            drop_q  <= 1'b0;
          end else begin
            i_q <= i_q + 1'b1;
            state_q <= StEmitRd;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_cnt_q <= Tw'(MaxTerms)) else $error("A count beyond capacity");
  b_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_cnt_q <= Tw'(MaxTerms)) else $error("B count beyond capacity");
  no_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == StEmit)) else $error("word outside emit");
  last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_o.last_term) |-> !busy_o) else $error("busy after last");

endmodule
